@@ src/deq_pkg.sv @@
// Shared constants, types and ring-index helpers for the double-ended queue.
// Used by double_ended_queue; no other dependencies.
package deq_pkg;

  localparam int DEPTH        = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int DUMP_MAX     = (DEPTH < RESULT_LIMIT) ? DEPTH : RESULT_LIMIT;

  localparam int CMD_W  = 3;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 6;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [STAT_W-1:0]        stat_t;
  typedef logic [OCC_W-1:0]         occ_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_DUMP       = 3'd4;

  localparam stat_t STAT_OK    = 2'd0;
  localparam stat_t STAT_EMPTY = 2'd1;
  localparam stat_t STAT_FULL  = 2'd2;

  typedef struct packed {
    stat_t status;
    word_t word;
    occ_t  occupancy;
    logic  last;
  } deq_res_t;

  function automatic idx_t ring_inc(idx_t idx);
    return (idx == idx_t'(DEPTH - 1)) ? '0 : idx_t'(idx + 1'b1);
  endfunction

  function automatic idx_t ring_dec(idx_t idx);
    return (idx == '0) ? idx_t'(DEPTH - 1) : idx_t'(idx - 1'b1);
  endfunction

  // Index plus an offset below DEPTH, wrapped once.
  function automatic idx_t ring_add(idx_t idx, cnt_t cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(cnt);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic occ_t to_occ(cnt_t cnt);
    return occ_t'(cnt);
  endfunction

endpackage

@@ src/double_ended_queue.sv @@
// Top level of the bounded double-ended queue: command sequencer and output register.
// Depends on deq_pkg and on deq_ram for the ring store.
//
// Usage: the input channel (in_valid, in_stall, in_cmd, in_value) carries one command
// per transaction: push front, push back, pop front, pop back or dump. The result
// channel (out_valid, out_stall, out_status, out_word, out_occupancy, out_last) carries
// one transaction per result; out_last marks the final result of a command. Unknown
// commands are consumed without a result.
// A push result, and the result of a pop or dump of an empty store, is loaded into the
// output register from the command register; a pop or dump result that reads the store
// passes through the registered read port of the ring store before the output register.
// Throughput: pushes, unknown commands and commands on an empty store go at one per
// cycle while the receiver does not stall; a pop holds the input until its store read
// returns, and a dump holds it while it streams one entry per cycle unless stalled.
// The ring store's single read port and the one-command sequencer set these limits.
// The command register takes the next command while a finished result still waits
// in the output register. When the receiver stalls, the output register holds and
// the sequencer waits, which in turn stalls the input channel.
// Reset (rst_n low, synchronous) empties the queue and drops any held result; the
// store contents are not cleared and no entry is read before it is written.
module double_ended_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  deq_pkg::cmd_t       in_cmd,
  input  deq_pkg::word_t      in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output deq_pkg::stat_t      out_status,
  output deq_pkg::word_t      out_word,
  output deq_pkg::occ_t       out_occupancy,
  output logic                out_last
);
  import deq_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_RDATA = 2'd2;

  logic [1:0] state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  word_t      val_r, val_nxt;
  idx_t       front_r, front_nxt;
  cnt_t       count_r, count_nxt;
  idx_t       rd_ptr_r, rd_ptr_nxt;
  cnt_t       rd_left_r, rd_left_nxt;
  deq_res_t   out_r, res;
  logic       out_valid_r;

  logic       out_free, out_load, done;
  logic       full, empty;
  cnt_t       dump_n;
  logic       wr_en, rd_en;
  idx_t       wr_addr, rd_addr;
  logic [WORD_W-1:0] rd_data;

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r == cnt_t'(DEPTH));
  assign empty    = (count_r == '0);
  assign dump_n   = (count_r > cnt_t'(DUMP_MAX)) ? cnt_t'(DUMP_MAX) : count_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    val_nxt     = val_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    rd_ptr_nxt  = rd_ptr_r;
    rd_left_nxt = rd_left_r;
    wr_en       = 1'b0;
    wr_addr     = front_r;
    rd_en       = 1'b0;
    rd_addr     = front_r;
    out_load    = 1'b0;
    done        = 1'b0;
    res.status    = STAT_OK;
    res.word      = val_r;
    res.occupancy = to_occ(count_r);
    res.last      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        done = 1'b1;
      end
      ST_EXEC: begin
        case (cmd_r)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (out_free) begin
              out_load = 1'b1;
              done     = 1'b1;
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = cnt_t'(count_r + 1'b1);
                res.occupancy = to_occ(cnt_t'(count_r + 1'b1));
                if (cmd_r == CMD_PUSH_FRONT) begin
                  wr_addr   = ring_dec(front_r);
                  front_nxt = ring_dec(front_r);
                end else begin
                  wr_addr = ring_add(front_r, count_r);
                end
              end
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK, CMD_DUMP: begin
            if (empty) begin
              if (out_free) begin
                out_load      = 1'b1;
                done          = 1'b1;
                res.status    = STAT_EMPTY;
                res.word      = '0;
                res.occupancy = '0;
              end
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_RDATA;
              if (cmd_r == CMD_DUMP) begin
                rd_addr     = front_r;
                rd_ptr_nxt  = ring_inc(front_r);
                rd_left_nxt = cnt_t'(dump_n - 1'b1);
              end else begin
                rd_left_nxt = '0;
                count_nxt   = cnt_t'(count_r - 1'b1);
                if (cmd_r == CMD_POP_FRONT) begin
                  rd_addr   = front_r;
                  front_nxt = ring_inc(front_r);
                end else begin
                  rd_addr = ring_add(front_r, cnt_t'(count_r - 1'b1));
                end
              end
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      ST_RDATA: begin
        if (out_free) begin
          out_load = 1'b1;
          res.word = word_t'(rd_data);
          res.last = (rd_left_r == '0);
          if (rd_left_r == '0) begin
            done = 1'b1;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = rd_ptr_r;
            rd_ptr_nxt  = ring_inc(rd_ptr_r);
            rd_left_nxt = cnt_t'(rd_left_r - 1'b1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      if (in_valid) begin
        cmd_nxt   = in_cmd;
        val_nxt   = in_value;
        state_nxt = ST_EXEC;
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  assign in_stall = !done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    rd_left_r <= rd_left_nxt;
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_word      = out_r.word;
  assign out_occupancy = out_r.occupancy;
  assign out_last      = out_r.last;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("entry count exceeds depth");

  a_write_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_EXEC) && !full)
    else $error("store write outside a push with room");

  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("store read and write in the same cycle");

  a_count_moves_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(state_r) == ST_EXEC))
    else $error("entry count changed outside command execution");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over an unaccepted result");

endmodule

@@ src/deq_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ verif/double_ended_queue_tb.sv @@
// Self-checking testbench for double_ended_queue: random stall and gap traffic on both
// channels, with every result predicted from a behavioral copy of the ring store.
// Depends on deq_pkg and double_ended_queue only.
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int ITEM_TARGET    = 480;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_ERR_LINES  = 40;

  typedef struct {
    cmd_t  cmd;
    word_t value;
  } deq_cmd_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  cmd_t   in_cmd    = CMD_PUSH_BACK;
  word_t  in_value  = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  stat_t  out_status;
  word_t  out_word;
  occ_t   out_occupancy;
  logic   out_last;

  deq_cmd_t    commands_queued[$];
  deq_res_t    outcomes_due[$];
  word_t       ring_mem[DEPTH];
  int unsigned ring_front = 0;
  int unsigned ring_held  = 0;
  int          gen_fill_level = 0;
  int          items_counted  = 0;
  int          commands_taken = 0;
  int          results_seen   = 0;
  int          error_count    = 0;
  int          tx_gap   = 0;
  int          tx_quiet = 0;
  int          rx_hold  = 0;
  int          rx_quiet = 0;

  double_ended_queue i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_word      (out_word),
    .out_occupancy (out_occupancy),
    .out_last      (out_last)
  );

  always #6 clk = ~clk;

  task automatic flag_error(string msg);
    if (error_count < MAX_ERR_LINES) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic void compute_deque_outcome(cmd_t c, word_t v);
    deq_res_t    res;
    int unsigned slot;
    int unsigned n;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (ring_held >= DEPTH) begin
          res = '{STAT_FULL, v, occ_t'(ring_held), 1'b1};
        end else begin
          if (c == CMD_PUSH_FRONT) begin
            ring_front = (ring_front + DEPTH - 1) % DEPTH;
            slot = ring_front;
          end else begin
            slot = (ring_front + ring_held) % DEPTH;
          end
          ring_mem[slot] = v;
          ring_held++;
          res = '{STAT_OK, v, occ_t'(ring_held), 1'b1};
        end
        outcomes_due.push_back(res);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_held == 0) begin
          res = '{STAT_EMPTY, word_t'(0), occ_t'(0), 1'b1};
        end else begin
          if (c == CMD_POP_FRONT) begin
            slot = ring_front;
            ring_front = (ring_front + 1) % DEPTH;
          end else begin
            slot = (ring_front + ring_held - 1) % DEPTH;
          end
          ring_held--;
          res = '{STAT_OK, ring_mem[slot], occ_t'(ring_held), 1'b1};
        end
        outcomes_due.push_back(res);
      end
      CMD_DUMP: begin
        if (ring_held == 0) begin
          outcomes_due.push_back('{STAT_EMPTY, word_t'(0), occ_t'(0), 1'b1});
        end else begin
          n = (ring_held > RESULT_LIMIT) ? RESULT_LIMIT : ring_held;
          for (int unsigned i = 0; i < n; i++) begin
            slot = (ring_front + i) % DEPTH;
            outcomes_due.push_back('{STAT_OK, ring_mem[slot], occ_t'(ring_held),
                                     (i + 1 == n)});
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return word_t'(32'h7FFF_FFFF);
    if (r < 8) return word_t'(32'h8000_0000);
    if (r < 11) return word_t'(0);
    if (r < 14) return word_t'(-1);
    if (r < 24) return word_t'($signed($urandom_range(0, 31)) - 16);
    return word_t'($urandom);
  endfunction

  task automatic queue_cmd(cmd_t c, word_t v);
    commands_queued.push_back('{c, v});
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (gen_fill_level < DEPTH) gen_fill_level++;
        items_counted++;
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (gen_fill_level > 0) gen_fill_level--;
        items_counted++;
      end
      CMD_DUMP: items_counted++;
      default: ;
    endcase
  endtask

  task automatic queue_push();
    queue_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word());
  endtask

  task automatic queue_pop();
    queue_cmd($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, pick_word());
  endtask

  task automatic queue_fill_run();
    while (gen_fill_level < DEPTH) begin
      case ($urandom_range(0, 9))
        0: queue_pop();
        1: queue_cmd(CMD_DUMP, pick_word());
        default: queue_push();
      endcase
    end
    repeat ($urandom_range(1, 3)) queue_push();
    if ($urandom_range(0, 1)) queue_cmd(CMD_DUMP, pick_word());
  endtask

  task automatic queue_drain_run();
    while (gen_fill_level > 0) begin
      case ($urandom_range(0, 9))
        0: queue_push();
        1: queue_cmd(CMD_DUMP, pick_word());
        default: queue_pop();
      endcase
    end
    repeat ($urandom_range(1, 2)) queue_pop();
    queue_cmd(CMD_DUMP, pick_word());
  endtask

  task automatic queue_mixed_run();
    int r;
    repeat ($urandom_range(10, 30)) begin
      r = $urandom_range(0, 99);
      if (r < 45) queue_push();
      else if (r < 82) queue_pop();
      else if (r < 96) queue_cmd(CMD_DUMP, pick_word());
      else queue_cmd(cmd_t'($urandom_range(5, 7)), pick_word());
    end
  endtask

  // Input side: once the current transaction is taken or none is pending, the next one is
  // presented unless a random gap is due; during a gap in_valid is low and the payload is scrambled.
  always @(posedge clk) begin
    deq_cmd_t nxt;
    int       r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
        in_cmd   <= cmd_t'($urandom);
        in_value <= word_t'($urandom);
      end else if (commands_queued.size() > 0) begin
        nxt = commands_queued.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= nxt.cmd;
        in_value <= nxt.value;
        r = $urandom_range(0, 99);
        if (tx_quiet > 0) begin
          tx_quiet--;
          tx_gap = 0;
        end else if (r < 4) begin
          tx_quiet = $urandom_range(20, 80);
          tx_gap = 0;
        end else if (r < 65) begin
          tx_gap = 0;
        end else if (r < 92) begin
          tx_gap = $urandom_range(1, 3);
        end else begin
          tx_gap = $urandom_range(8, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (rx_quiet > 0) begin
      rx_quiet--;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        rx_quiet = $urandom_range(30, 100);
        out_stall <= 1'b0;
      end else if (r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 93) begin
        rx_hold = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        rx_hold = $urandom_range(7, 29);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    deq_res_t due;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        compute_deque_outcome(in_cmd, in_value);
        commands_taken++;
      end
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          flag_error($sformatf("result with none expected: status %0d word %0d",
                               out_status, out_word));
        end else begin
          due = outcomes_due.pop_front();
          if (out_status !== due.status) begin
            flag_error($sformatf("result %0d: status %0d, expected %0d",
                                 results_seen, out_status, due.status));
          end
          if (out_word !== due.word) begin
            flag_error($sformatf("result %0d: word %0d, expected %0d",
                                 results_seen, out_word, due.word));
          end
          if (out_occupancy !== due.occupancy) begin
            flag_error($sformatf("result %0d: occupancy %0d, expected %0d",
                                 results_seen, out_occupancy, due.occupancy));
          end
          if (out_last !== due.last) begin
            flag_error($sformatf("result %0d: last %0b, expected %0b",
                                 results_seen, out_last, due.last));
          end
        end
        results_seen++;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
    $display("double_ended_queue_tb: errors");
    $finish;
  end

  initial begin
    int stim_total;
    int r;

    queue_cmd(CMD_POP_FRONT, word_t'(32'h1234_5678));
    queue_cmd(CMD_POP_BACK, word_t'(-1));
    queue_cmd(CMD_DUMP, word_t'(0));
    queue_cmd(cmd_t'(5), word_t'(1));
    queue_cmd(cmd_t'(6), word_t'(2));
    queue_cmd(cmd_t'(7), word_t'(-1));
    queue_cmd(CMD_PUSH_FRONT, word_t'(32'h7FFF_FFFF));
    queue_cmd(CMD_PUSH_BACK, word_t'(32'h8000_0000));
    queue_cmd(CMD_PUSH_FRONT, word_t'(0));
    queue_cmd(CMD_PUSH_BACK, word_t'(-1));
    queue_cmd(CMD_PUSH_FRONT, word_t'(32'h5555_5555));
    queue_cmd(CMD_PUSH_BACK, word_t'(32'hAAAA_AAAA));
    queue_cmd(CMD_DUMP, word_t'(-1));
    queue_cmd(CMD_POP_FRONT, word_t'(0));
    queue_cmd(CMD_POP_BACK, word_t'(0));
    queue_cmd(CMD_POP_BACK, word_t'(0));
    queue_cmd(CMD_POP_FRONT, word_t'(0));
    queue_cmd(CMD_DUMP, word_t'(0));
    queue_cmd(CMD_POP_FRONT, word_t'(0));
    queue_cmd(CMD_POP_BACK, word_t'(0));
    queue_cmd(CMD_POP_FRONT, word_t'(0));
    queue_cmd(CMD_POP_BACK, word_t'(0));
    queue_cmd(CMD_DUMP, word_t'(0));

    items_counted = 0;
    while (items_counted < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      if (r < 3) queue_fill_run();
      else if (r < 6) queue_drain_run();
      else queue_mixed_run();
    end
    stim_total = commands_queued.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (commands_taken < stim_total) @(negedge clk);
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("double_ended_queue_tb: clean");
    end else begin
      $display("double_ended_queue_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/deq_pkg.sv
src/deq_ram.sv
src/double_ended_queue.sv
verif/double_ended_queue_tb.sv
